// ===== rtl/rhc_pkg.sv =====
// Package for the RGB to HSV converter: constants, item types and sector codes.
`timescale 1ns / 1ps
package rhc_pkg;

  localparam int CHANNEL_BITS  = 8;
  localparam int HUE_FRAC_BITS = 6;
  localparam int SAT_BITS      = 12;
  localparam int HUE_W         = 15;
  localparam int SAT_W         = 13;
  localparam int VAL_W         = 8;

  localparam int QH_BITS = HUE_FRAC_BITS + 6;
  localparam int QS_BITS = SAT_BITS + 1;
  localparam int STEPS   = (QH_BITS > QS_BITS) ? QH_BITS : QS_BITS;
  localparam int REM_W   = CHANNEL_BITS + STEPS;
  localparam int HSUM_W  = HUE_FRAC_BITS + 11;

  localparam int HUE_UNIT  = 1 << HUE_FRAC_BITS;
  localparam int HUE_60    = 60 * HUE_UNIT;
  localparam int HUE_120   = 120 * HUE_UNIT;
  localparam int HUE_240   = 240 * HUE_UNIT;
  localparam int HUE_360   = 360 * HUE_UNIT;
  localparam int SAT_ONE   = 1 << SAT_BITS;

  typedef logic [1:0] sector_t;
  localparam sector_t SEC_RED   = 2'd0;
  localparam sector_t SEC_GREEN = 2'd1;
  localparam sector_t SEC_BLUE  = 2'd2;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue_out;
    logic [SAT_W-1:0] saturation_out;
    logic [VAL_W-1:0] value_out;
  } hsv_t;

  typedef struct packed {
    logic [REM_W-1:0]        rem_h;
    logic [REM_W-1:0]        rem_s;
    logic [CHANNEL_BITS-1:0] den_h;
    logic [CHANNEL_BITS-1:0] den_s;
    logic [STEPS-1:0]        q_h;
    logic [STEPS-1:0]        q_s;
    logic                    neg;
    logic                    zero;
    sector_t                 sector;
  } work_t;

endpackage

// ===== rtl/rhc_front.sv =====
// Front cell: max, min, delta, sector and dividends of one pixel.
`timescale 1ns / 1ps
module rhc_front import rhc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   valid_in,
  input  pixel_t pixel,
  output logic   valid,
  output work_t  work
);

  logic [CHANNEL_BITS-1:0] r, g, b, hi, lo, delta, absd;
  logic                    neg;
  sector_t                 sector;
  work_t                   work_next;

  always_comb begin
    r = pixel.red_in[CHANNEL_BITS-1:0];
    g = pixel.green_in[CHANNEL_BITS-1:0];
    b = pixel.blue_in[CHANNEL_BITS-1:0];
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    delta = hi - lo;
    if (hi == r) begin
      sector = SEC_RED;
      neg = b > g;
      absd = neg ? b - g : g - b;
    end else if (hi == g) begin
      sector = SEC_GREEN;
      neg = r > b;
      absd = neg ? r - b : b - r;
    end else begin
      sector = SEC_BLUE;
      neg = g > r;
      absd = neg ? g - r : r - g;
    end
    work_next.rem_h  = REM_W'(absd) * REM_W'(HUE_60);
    work_next.rem_s  = REM_W'(delta) << SAT_BITS;
    work_next.den_h  = delta;
    work_next.den_s  = hi;
    work_next.q_h    = '0;
    work_next.q_s    = '0;
    work_next.neg    = neg;
    work_next.zero   = (delta == '0);
    work_next.sector = sector;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work <= work_next;
    end
  end

endmodule

// ===== rtl/rhc_div_cell.sv =====
// Divider cell: one restoring quotient bit for both hue and saturation.
`timescale 1ns / 1ps
module rhc_div_cell import rhc_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  valid_in,
  input  work_t work_in,
  output logic  valid,
  output work_t work
);

  logic [REM_W-1:0] sh_h, sh_s;
  logic             bit_h, bit_s;
  work_t            work_next;

  always_comb begin
    sh_h  = REM_W'(work_in.den_h) << BIT;
    sh_s  = REM_W'(work_in.den_s) << BIT;
    bit_h = work_in.rem_h >= sh_h;
    bit_s = work_in.rem_s >= sh_s;
    work_next       = work_in;
    work_next.rem_h = bit_h ? work_in.rem_h - sh_h : work_in.rem_h;
    work_next.rem_s = bit_s ? work_in.rem_s - sh_s : work_in.rem_s;
    work_next.q_h   = {work_in.q_h[STEPS-2:0], bit_h};
    work_next.q_s   = {work_in.q_s[STEPS-2:0], bit_s};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work <= work_next;
    end
  end

endmodule

// ===== rtl/rgb_to_hsv_convert.sv =====
// Top level: RGB to HSV converter, front cell, divider cell chain, hue fixup.
// Stages: front cell, one divider cell per quotient bit, output register.
// Throughput: one item per cycle; the whole chain holds while the output stalls.
// Reset: synchronous rst clears all valid bits; payload registers keep contents.
`timescale 1ns / 1ps
module rgb_to_hsv_convert import rhc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  pixel_t pixel,
  input  logic   pixel_valid,
  output logic   pixel_stall,
  output hsv_t   hsv,
  output logic   hsv_valid,
  input  logic   hsv_stall
);

  logic              en;
  logic [STEPS:0]    vld;
  work_t             wk [STEPS+1];
  logic signed [HSUM_W-1:0] off, hue_sum, hue_fix;
  work_t             last;
  hsv_t              hsv_next;

  assign en          = !(hsv_valid && hsv_stall);
  assign pixel_stall = !en;

  rhc_front u_front (
    .clk(clk), .rst(rst), .en(en), .valid_in(pixel_valid), .pixel(pixel),
    .valid(vld[0]), .work(wk[0])
  );

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    rhc_div_cell #(.BIT(STEPS - 1 - k)) u_cell (
      .clk(clk), .rst(rst), .en(en), .valid_in(vld[k]), .work_in(wk[k]),
      .valid(vld[k+1]), .work(wk[k+1])
    );
  end

  always_comb begin
    last = wk[STEPS];
    case (last.sector)
      SEC_GREEN: off = HSUM_W'(HUE_120);
      SEC_BLUE:  off = HSUM_W'(HUE_240);
      default:   off = '0;
    endcase
    hue_sum = last.neg ? off - $signed(HSUM_W'(last.q_h)) : off + $signed(HSUM_W'(last.q_h));
    hue_fix = (hue_sum < 0) ? hue_sum + HSUM_W'(HUE_360) : hue_sum;
    hsv_next.value_out      = VAL_W'(last.den_s);
    hsv_next.hue_out        = last.zero ? '0 : HUE_W'(hue_fix);
    hsv_next.saturation_out = last.zero ? '0 : SAT_W'(last.q_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hsv_valid <= 1'b0;
    end else if (en) begin
      hsv_valid <= vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hsv <= hsv_next;
    end
  end

  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> (hsv.saturation_out <= SAT_W'(SAT_ONE)))
    else $error("saturation above one");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> (hsv.hue_out < HUE_W'(HUE_360)))
    else $error("hue not below 360 degrees");

  a_black: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && hsv.value_out == '0) |-> (hsv.saturation_out == '0 && hsv.hue_out == '0))
    else $error("black pixel with nonzero hue or saturation");

endmodule
